// ===== src/sgrp_pkg.sv =====
// Shared types, constants and lookup functions for the staggered gamma RGB PWM block.
// Used by sgrp_channel and staggered_gamma_rgb_pwm_top; depends on nothing else.
package sgrp_pkg;

    // Channel count default and fixed field widths
    localparam int unsigned CHANNELS_DEF = 3;
    localparam int unsigned ENABLE_W     = 3;
    localparam int unsigned PIN_W        = 3;
    localparam int unsigned DUTY_W       = 8;
    localparam int unsigned WORD_W       = 24;
    localparam int unsigned CH_IDX_W     = 2;
    localparam int unsigned COUNT_W      = 2;

    localparam logic [DUTY_W-1:0] COUNTER_LAST = 8'd254;
    localparam logic [DUTY_W-1:0] DUTY_FULL    = 8'hFF;

    // Operation codes of an input transaction
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [WORD_W-1:0]  colour_word;
    } t_in_item;

    typedef struct packed {
        logic [PIN_W-1:0]   pin_levels;
        logic [DUTY_W-1:0]  cycle_position;
    } t_out_item;

    // Per-channel control, shared by the top level with each channel
    typedef struct packed {
        logic               tick;
        logic               load;
        logic               enable;
        logic [DUTY_W-1:0]  on_point;
    } t_chan_ctrl;

    // CIE lightness to duty mapping
    localparam logic [DUTY_W-1:0] CIE_TABLE [256] = '{
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
        8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,
        8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,8'd5,8'd5,8'd6,8'd6,8'd6,8'd6,
        8'd6,8'd7,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,8'd10,8'd10,8'd11,
        8'd11,8'd11,8'd12,8'd12,8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd14,8'd15,8'd15,8'd16,
        8'd16,8'd16,
        8'd17,8'd17,8'd18,8'd18,8'd19,8'd19,8'd20,8'd20,8'd21,8'd21,8'd22,8'd22,8'd23,8'd23,
        8'd24,8'd24,
        8'd25,8'd25,8'd26,8'd26,8'd27,8'd28,8'd28,8'd29,8'd29,8'd30,8'd31,8'd31,8'd32,8'd33,
        8'd33,8'd34,
        8'd35,8'd35,8'd36,8'd37,8'd37,8'd38,8'd39,8'd40,8'd40,8'd41,8'd42,8'd43,8'd44,8'd44,
        8'd45,8'd46,
        8'd47,8'd48,8'd49,8'd49,8'd50,8'd51,8'd52,8'd53,8'd54,8'd55,8'd56,8'd57,8'd58,8'd59,
        8'd60,8'd61,
        8'd62,8'd63,8'd64,8'd65,8'd66,8'd67,8'd68,8'd69,8'd70,8'd71,8'd72,8'd73,8'd75,8'd76,
        8'd77,8'd78,
        8'd79,8'd80,8'd82,8'd83,8'd84,8'd85,8'd87,8'd88,8'd89,8'd90,8'd92,8'd93,8'd94,8'd96,
        8'd97,8'd99,
        8'd100,8'd101,8'd103,8'd104,8'd106,8'd107,8'd108,8'd110,8'd111,8'd113,8'd114,8'd116,
        8'd118,8'd119,8'd121,8'd122,
        8'd124,8'd125,8'd127,8'd129,8'd130,8'd132,8'd134,8'd135,8'd137,8'd139,8'd141,8'd142,
        8'd144,8'd146,8'd148,8'd149,
        8'd151,8'd153,8'd155,8'd157,8'd159,8'd161,8'd162,8'd164,8'd166,8'd168,8'd170,8'd172,
        8'd174,8'd176,8'd178,8'd180,
        8'd182,8'd185,8'd187,8'd189,8'd191,8'd193,8'd195,8'd197,8'd200,8'd202,8'd204,8'd206,
        8'd208,8'd211,8'd213,8'd215,
        8'd218,8'd220,8'd222,8'd225,8'd227,8'd230,8'd232,8'd234,8'd237,8'd239,8'd242,8'd244,
        8'd247,8'd249,8'd252,8'd255
    };

    function automatic logic [DUTY_W-1:0] cie_lookup(input logic [DUTY_W-1:0] lightness);
        return CIE_TABLE[lightness];
    endfunction

    // Staggered on point: idx * (256 / count), truncated to 8 bits; zero count acts as one
    function automatic logic [DUTY_W-1:0] on_point(input logic [CH_IDX_W-1:0] idx,
                                                   input logic [COUNT_W-1:0]  count);
        logic [DUTY_W-1:0] pos;
        pos = '0;
        case (count)
            2'd2:    pos = idx[0] ? 8'd128 : 8'd0;
            2'd3:    pos = 8'({6'd0, idx} * 8'd85);
            default: pos = '0;
        endcase
        return pos;
    endfunction

endpackage

// ===== src/staggered_gamma_rgb_pwm_top.sv =====
// Top level of the staggered gamma RGB PWM block.
// Depends on sgrp_pkg and instantiates one sgrp_channel per channel.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries transactions of
//   two kinds: OP_TICK advances the PWM counter (0..254) and updates the pin
//   levels; OP_LOAD maps the three colour bytes through the CIE lightness table
//   and stores the new duty and off points. Every transaction yields exactly one
//   result on the output channel (o_out_valid / i_out_stall / o_out_item) with
//   the pin levels and counter value after that transaction.
//   A result is in the output register the cycle after its transaction is
//   accepted. Throughput is one transaction per cycle while the receiver does
//   not stall; the per-item path is one table read, an 8-bit add and a few 8-bit compares.
//   When the receiver stalls, the output register holds its result and o_in_stall
//   rises until it is taken; a new transaction is accepted in the same cycle
//   the held result leaves.
//   i_cfg_we writes channel_enable from i_cfg_data; write only while idle.
//   Synchronous active-low reset enables all channels, zeroes the counter, duties,
//   off points and levels, and empties the output register.
module staggered_gamma_rgb_pwm_top #(
    parameter int unsigned CHANNELS = sgrp_pkg::CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  sgrp_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output sgrp_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_we,
    input  logic [sgrp_pkg::ENABLE_W-1:0]   i_cfg_data
);

    logic [sgrp_pkg::ENABLE_W-1:0] r_enable;
    logic [sgrp_pkg::DUTY_W-1:0]   r_counter, n_counter;
    logic                          r_out_valid;
    sgrp_pkg::t_out_item           r_out_item;

    logic                          in_accept;
    logic                          is_tick;
    logic                          is_load;
    logic [sgrp_pkg::ENABLE_W-1:0] en_eff;
    logic [sgrp_pkg::COUNT_W-1:0]  en_count;
    logic [CHANNELS-1:0]           level_next;
    logic [sgrp_pkg::PIN_W-1:0]    pins_next;

    // Accept whenever the output register is empty or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign is_tick    = in_accept && (i_in_item.op == sgrp_pkg::OP_TICK);
    assign is_load    = in_accept && (i_in_item.op == sgrp_pkg::OP_LOAD);

    // Keep only enable bits of channels that exist, then count them
    for (genvar k = 0; k < sgrp_pkg::ENABLE_W; k++) begin : g_en
        if (k < CHANNELS) begin : g_on
            assign en_eff[k] = r_enable[k];
        end else begin : g_off
            assign en_eff[k] = 1'b0;
        end
    end
    assign en_count = sgrp_pkg::COUNT_W'({1'b0, en_eff[0]} + {1'b0, en_eff[1]}
                                         + {1'b0, en_eff[2]});

    // Channels
    for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
        sgrp_pkg::t_chan_ctrl        ctrl;
        logic [sgrp_pkg::DUTY_W-1:0] target;

        if (i < sgrp_pkg::ENABLE_W) begin : g_word
            assign target      = i_in_item.colour_word[sgrp_pkg::DUTY_W*i +: sgrp_pkg::DUTY_W];
            assign ctrl.enable = en_eff[i];
        end else begin : g_none
            assign target      = '0;
            assign ctrl.enable = 1'b0;
        end
        assign ctrl.tick     = is_tick;
        assign ctrl.load     = is_load;
        assign ctrl.on_point = sgrp_pkg::on_point(sgrp_pkg::CH_IDX_W'(i), en_count);

        sgrp_channel u_channel (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_target     (target),
            .i_counter    (r_counter),
            .o_level_next (level_next[i])
        );
    end

    // Report only the first three channels; missing ones read low
    for (genvar j = 0; j < sgrp_pkg::PIN_W; j++) begin : g_pin
        if (j < CHANNELS) begin : g_have
            assign pins_next[j] = level_next[j];
        end else begin : g_miss
            assign pins_next[j] = 1'b0;
        end
    end

    // Advance the counter on a tick, wrapping after 254
    always_comb begin
        n_counter = r_counter;
        if (is_tick) begin
            n_counter = (r_counter == sgrp_pkg::COUNTER_LAST) ? '0 : r_counter + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= '1;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_data;
            end
            r_counter <= n_counter;
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result of each accepted transaction
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_item.pin_levels     <= pins_next;
            r_out_item.cycle_position <= n_counter;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.cycle_position != sgrp_pkg::DUTY_FULL)
        else $error("cycle position reached 255");

    a_load_holds_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_load |=> r_counter == $past(r_counter))
        else $error("colour load moved the counter");

    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_tick && r_counter != sgrp_pkg::COUNTER_LAST)
            |=> r_counter == $past(r_counter) + 8'd1)
        else $error("tick did not advance the counter");

    a_tick_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_tick && r_counter == sgrp_pkg::COUNTER_LAST) |=> r_counter == '0)
        else $error("counter did not wrap after 254");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted transaction produced no result");

endmodule

// ===== src/sgrp_channel.sv =====
// One PWM channel: duty and off point storage, level compare logic.
// Depends on sgrp_pkg for the CIE table, control struct and widths.
module sgrp_channel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sgrp_pkg::t_chan_ctrl          i_ctrl,
    input  logic [sgrp_pkg::DUTY_W-1:0]   i_target,
    input  logic [sgrp_pkg::DUTY_W-1:0]   i_counter,
    output logic                          o_level_next
);

    logic [sgrp_pkg::DUTY_W-1:0] r_duty, n_duty;
    logic [sgrp_pkg::DUTY_W-1:0] r_off,  n_off;
    logic                        r_level, n_level;
    logic [sgrp_pkg::DUTY_W-1:0] off_sum;

    // Map the target, place the off point after the on point, fold 255 to 0
    always_comb begin
        n_duty  = r_duty;
        n_off   = r_off;
        n_level = r_level;
        off_sum = i_ctrl.on_point + sgrp_pkg::cie_lookup(i_target);
        if (i_ctrl.load) begin
            n_duty = sgrp_pkg::cie_lookup(i_target);
            n_off  = (off_sum == sgrp_pkg::DUTY_FULL) ? '0 : off_sum;
        end else if (i_ctrl.tick && i_ctrl.enable) begin
            if (r_off == i_counter && r_duty != sgrp_pkg::DUTY_FULL) begin
                n_level = 1'b1;
            end else if (i_ctrl.on_point == i_counter && r_duty != '0) begin
                n_level = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty  <= '0;
            r_off   <= '0;
            r_level <= 1'b0;
        end else begin
            r_duty  <= n_duty;
            r_off   <= n_off;
            r_level <= n_level;
        end
    end

    assign o_level_next = n_level;

endmodule
